// ===== src/assert_macros.svh =====
// assertion macros shared by the odometry block
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== src/mop_pkg.sv =====
`timescale 1ns / 1ps
// types, constants, sine rom and control program of the odometry pose update
// no dependencies; used by every file of the block except assert_macros.svh
package mop_pkg;

	// field widths
	localparam int SPEED_W     = 16;
	localparam int STEP_TIME_W = 16;
	localparam int GAIN_W      = 32;
	localparam int GAIN_HALF_W = GAIN_W / 2;
	localparam int POS_W       = 32;
	localparam int HEAD_W      = 16;
	localparam int TRIG_W      = 16;
	localparam int TRIG_FRAC   = TRIG_W - 1;

	// datapath widths
	localparam int SUM_W    = SPEED_W + 2;
	localparam int T_W      = SUM_W + STEP_TIME_W;
	localparam int D_W      = T_W;
	localparam int MUL_A_W  = D_W + 1;
	localparam int MUL_B_W  = GAIN_HALF_W + 2;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int ACC_W    = T_W + GAIN_W + 1;
	localparam int DELTA_W  = ACC_W - TRIG_FRAC;
	localparam int PSUM_W   = DELTA_W + 1;

	// configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = GAIN_W;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_GAIN = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_TURN_GAIN  = CFG_INDEX_W'(1);

	// sine table
	localparam int SINE_TABLE_BITS = 8;
	localparam int SINE_TBL_SIZE   = 1 << SINE_TABLE_BITS;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
	localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(32767);

	typedef logic signed [TRIG_W-1:0] sine_rom_t [SINE_TBL_SIZE];
	typedef logic [SINE_TABLE_BITS-1:0] sine_idx_t;

	// quarter-wave sine in q1.15 from a q30 taylor series, rounded half up
	function automatic sine_rom_t make_sine_rom();
		sine_rom_t rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		for (int i = 0; i < SINE_TBL_SIZE; i++) begin
			x = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
			x2 = (x * x) >> 30;
			term = x;
			sum = signed'(x);
			for (int k = 1; k <= 6; k++) begin
				term = (term * x2) >> 30;
				term = term / TAYLOR_DIV[k];
				if ((k % 2) == 1) begin
					sum = sum - signed'(term);
				end else begin
					sum = sum + signed'(term);
				end
			end
			if (sum < 0) begin
				sum = '0;
			end
			sum = (sum + 64'sd16384) >>> 15;
			if (sum > 64'sd32767) begin
				sum = 64'sd32767;
			end
			rom[i] = sum[TRIG_W-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = make_sine_rom();

	// sine of a binary angle: quadrant from the top two bits, index below
	function automatic logic signed [TRIG_W-1:0] sine_lookup(logic [HEAD_W-1:0] a);
		sine_idx_t idx;
		logic signed [TRIG_W-1:0] v;
		idx = a[HEAD_W-3 -: SINE_TABLE_BITS];
		if (a[HEAD_W-2]) begin
			if (idx == '0) begin
				v = TRIG_ONE;
			end else begin
				v = SINE_ROM[sine_idx_t'(~idx + sine_idx_t'(1))];
			end
		end else begin
			v = SINE_ROM[idx];
		end
		if (a[HEAD_W-1]) begin
			v = -v;
		end
		return v;
	endfunction

	// payloads
	typedef struct packed {
		logic signed [SPEED_W-1:0] front_left_speed;
		logic signed [SPEED_W-1:0] front_right_speed;
		logic signed [SPEED_W-1:0] rear_left_speed;
		logic signed [SPEED_W-1:0] rear_right_speed;
		logic [STEP_TIME_W-1:0]    step_time;
	} sample_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [HEAD_W-1:0] heading;
	} pose_t;

	// axis being scaled in the gain loop
	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_W = 2'd2;

	// microcode fields
	typedef enum logic [1:0] {A_SUM, A_T, A_DX, A_DY} a_sel_t;
	typedef enum logic [2:0] {B_DT, B_GHI, B_GLO, B_COS, B_SIN} b_sel_t;
	typedef enum logic [2:0] {ACC_NOP, ACC_LOAD, ACC_SHADD, ACC_ADD, ACC_SUB} acc_op_t;
	typedef enum logic [1:0] {JMP_NONE, JMP_DT_ZERO, JMP_AXIS_MORE} jump_t;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t S_IDLE    = 4'd0;
	localparam step_t S_TRIG    = 4'd1;
	localparam step_t S_SUM_MUL = 4'd2;
	localparam step_t S_T_WR    = 4'd3;
	localparam step_t S_GHI_MUL = 4'd4;
	localparam step_t S_GLO_MUL = 4'd5;
	localparam step_t S_SHADD   = 4'd6;
	localparam step_t S_D_WR    = 4'd7;
	localparam step_t S_XC_MUL  = 4'd8;
	localparam step_t S_YS_MUL  = 4'd9;
	localparam step_t S_X_SUB   = 4'd10;
	localparam step_t S_X_WR    = 4'd11;
	localparam step_t S_Y_ADD   = 4'd12;
	localparam step_t S_Y_WR    = 4'd13;
	localparam step_t S_DONE    = 4'd14;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		logic    mul_en;
		acc_op_t acc_op;
		logic    t_we;
		logic    d_we;
		logic    trig_we;
		logic    x_we;
		logic    y_we;
		logic    h_we;
		jump_t   jump;
		step_t   target;
		logic    done;
	} ctrl_word_t;

	typedef struct packed {
		ctrl_word_t w;
		axis_t      axis;
	} dp_ctrl_t;

	typedef struct packed {
		logic dt_zero;
	} dp_stat_t;

	// control program; the product register is loaded by a multiply step and read by the step after it
	function automatic ctrl_word_t mc_rom(step_t step);
		ctrl_word_t w;
		w = '0;
		case (step)
			S_TRIG: begin
				w.trig_we = 1'b1;
				w.jump = JMP_DT_ZERO;
				w.target = S_DONE;
			end
			S_SUM_MUL: begin
				w.a_sel = A_SUM;
				w.b_sel = B_DT;
				w.mul_en = 1'b1;
			end
			S_T_WR: begin
				w.t_we = 1'b1;
			end
			S_GHI_MUL: begin
				w.a_sel = A_T;
				w.b_sel = B_GHI;
				w.mul_en = 1'b1;
			end
			S_GLO_MUL: begin
				w.a_sel = A_T;
				w.b_sel = B_GLO;
				w.mul_en = 1'b1;
				w.acc_op = ACC_LOAD;
			end
			S_SHADD: begin
				w.acc_op = ACC_SHADD;
			end
			S_D_WR: begin
				w.d_we = 1'b1;
				w.jump = JMP_AXIS_MORE;
				w.target = S_SUM_MUL;
			end
			S_XC_MUL: begin
				w.a_sel = A_DX;
				w.b_sel = B_COS;
				w.mul_en = 1'b1;
			end
			S_YS_MUL: begin
				w.a_sel = A_DY;
				w.b_sel = B_SIN;
				w.mul_en = 1'b1;
				w.acc_op = ACC_LOAD;
			end
			S_X_SUB: begin
				w.a_sel = A_DX;
				w.b_sel = B_SIN;
				w.mul_en = 1'b1;
				w.acc_op = ACC_SUB;
			end
			S_X_WR: begin
				w.a_sel = A_DY;
				w.b_sel = B_COS;
				w.mul_en = 1'b1;
				w.acc_op = ACC_LOAD;
				w.x_we = 1'b1;
			end
			S_Y_ADD: begin
				w.acc_op = ACC_ADD;
			end
			S_Y_WR: begin
				w.y_we = 1'b1;
				w.h_we = 1'b1;
			end
			S_DONE: begin
				w.done = 1'b1;
			end
			default: begin
				w = '0;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== src/mop_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces: wheel samples in, pose out, config writes
// depends on mop_pkg for the payload types and config widths
interface mop_in_if;
	import mop_pkg::*;
	logic    valid;
	logic    ready;
	sample_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface mop_out_if;
	import mop_pkg::*;
	logic  valid;
	logic  ready;
	pose_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface mop_cfg_if;
	import mop_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  wdata;
	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

// ===== src/mop_sequencer.sv =====
`timescale 1ns / 1ps
// step counter and control rom for the odometry datapath
// depends on mop_pkg (control word, program) and assert_macros.svh
`include "assert_macros.svh"
module mop_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              out_free,
	input  mop_pkg::dp_stat_t stat,
	output mop_pkg::dp_ctrl_t ctrl,
	output logic              idle
);
	import mop_pkg::*;

	step_t      step_q;
	step_t      step_d;
	axis_t      ax_q;
	axis_t      ax_d;
	ctrl_word_t word;
	logic       taken;

	always_comb begin
		word = mc_rom(step_q);
		case (word.jump)
			JMP_DT_ZERO:   taken = stat.dt_zero;
			JMP_AXIS_MORE: taken = (ax_q != AXIS_W);
			default:       taken = 1'b0;
		endcase
		step_d = step_q;
		ax_d = ax_q;
		if (step_q == S_IDLE) begin
			if (start) begin
				step_d = S_TRIG;
				ax_d = AXIS_X;
			end
		end else if (word.done) begin
			// hold the last step until the output register can take the pose
			if (out_free) begin
				step_d = S_IDLE;
			end
		end else if (taken) begin
			step_d = word.target;
			if (word.jump == JMP_AXIS_MORE) begin
				ax_d = ax_q + axis_t'(1);
			end
		end else begin
			step_d = step_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
			ax_q <= AXIS_X;
		end else begin
			step_q <= step_d;
			ax_q <= ax_d;
		end
	end

	assign ctrl.w = word;
	assign ctrl.axis = ax_q;
	assign idle = (step_q == S_IDLE);

	`ASSERT_NEXT(a_start_trig, clk, arst_n, start && step_q == S_IDLE, step_q == S_TRIG)
	`ASSERT_NEXT(a_zero_skip, clk, arst_n, step_q == S_TRIG && stat.dt_zero, step_q == S_DONE)
	`ASSERT_IMPL(a_axis_range, clk, arst_n, step_q == S_D_WR, ax_q == AXIS_X || ax_q == AXIS_Y || ax_q == AXIS_W)

endmodule

// ===== src/mop_datapath.sv =====
`timescale 1ns / 1ps
// shared multiplier, accumulator and pose registers driven by the control word
// depends on mop_pkg (widths, sine lookup, control types)
module mop_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  mop_pkg::sample_t                   sample_in,
	input  logic [mop_pkg::GAIN_W-1:0]         speed_gain,
	input  logic [mop_pkg::GAIN_W-1:0]         turn_gain,
	input  mop_pkg::dp_ctrl_t                  ctrl,
	output mop_pkg::dp_stat_t                  stat,
	output mop_pkg::pose_t                     pose_cur
);
	import mop_pkg::*;

	// add a rotated displacement to a position, clamping to 32 bits
	function automatic logic signed [POS_W-1:0] sat_add(
		logic signed [POS_W-1:0]   p,
		logic signed [DELTA_W-1:0] d
	);
		logic signed [PSUM_W-1:0] s;
		logic signed [POS_W-1:0]  r;
		s = PSUM_W'(p) + PSUM_W'(d);
		if (s[PSUM_W-1:POS_W-1] == '0 || s[PSUM_W-1:POS_W-1] == '1) begin
			r = s[POS_W-1:0];
		end else if (s[PSUM_W-1]) begin
			r = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(POS_W-1){1'b1}}};
		end
		return r;
	endfunction

	logic signed [SUM_W-1:0]   fl, fr, rl, rr;
	logic signed [SUM_W-1:0]   sx_q, sy_q, sw_q;
	logic [STEP_TIME_W-1:0]    dt_q;
	logic signed [TRIG_W-1:0]  sn_q, cs_q;
	logic signed [T_W-1:0]     t_q;
	logic signed [D_W-1:0]     dx_q, dy_q;
	logic [HEAD_W-1:0]         dh_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [POS_W-1:0]   x_q, y_q;
	logic [HEAD_W-1:0]         heading_q;

	logic signed [SUM_W-1:0]   sum_sel;
	logic [GAIN_W-1:0]         gain_sel;
	logic signed [MUL_A_W-1:0] a_op;
	logic signed [MUL_B_W-1:0] b_op;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [DELTA_W-1:0] delta;

	assign fl = SUM_W'(sample_in.front_left_speed);
	assign fr = SUM_W'(sample_in.front_right_speed);
	assign rl = SUM_W'(sample_in.rear_left_speed);
	assign rr = SUM_W'(sample_in.rear_right_speed);

	always_comb begin
		case (ctrl.axis)
			AXIS_X:  sum_sel = sx_q;
			AXIS_Y:  sum_sel = sy_q;
			default: sum_sel = sw_q;
		endcase
		gain_sel = (ctrl.axis == AXIS_W) ? turn_gain : speed_gain;
		case (ctrl.w.a_sel)
			A_SUM:   a_op = MUL_A_W'(sum_sel);
			A_T:     a_op = MUL_A_W'(t_q);
			A_DX:    a_op = MUL_A_W'(dx_q);
			A_DY:    a_op = MUL_A_W'(dy_q);
			default: a_op = '0;
		endcase
		case (ctrl.w.b_sel)
			B_DT:    b_op = signed'(MUL_B_W'(dt_q));
			B_GHI:   b_op = signed'(MUL_B_W'(gain_sel[GAIN_W-1:GAIN_HALF_W]));
			B_GLO:   b_op = signed'(MUL_B_W'(gain_sel[GAIN_HALF_W-1:0]));
			B_COS:   b_op = MUL_B_W'(cs_q);
			B_SIN:   b_op = MUL_B_W'(sn_q);
			default: b_op = '0;
		endcase
	end

	assign prod_ext = ACC_W'(prod_q);
	// rotated sum floored by 2^15
	assign delta = acc_q[ACC_W-1:TRIG_FRAC];

	always_ff @(posedge clk) begin
		if (start) begin
			sx_q <= fl + fr + rl + rr;
			sy_q <= fr + rl - fl - rr;
			sw_q <= fr + rr - fl - rl;
			dt_q <= sample_in.step_time;
		end
		if (ctrl.w.trig_we) begin
			sn_q <= sine_lookup(heading_q);
			cs_q <= sine_lookup(heading_q + HEAD_W'(16'h4000));
		end
		if (ctrl.w.mul_en) begin
			prod_q <= PROD_W'(a_op) * PROD_W'(b_op);
		end
		if (ctrl.w.t_we) begin
			t_q <= prod_q[T_W-1:0];
		end
		case (ctrl.w.acc_op)
			ACC_LOAD:  acc_q <= prod_ext;
			ACC_SHADD: acc_q <= (acc_q <<< GAIN_HALF_W) + prod_ext;
			ACC_ADD:   acc_q <= acc_q + prod_ext;
			ACC_SUB:   acc_q <= acc_q - prod_ext;
			default:   acc_q <= acc_q;
		endcase
		// body displacement is the gain product shifted right by 32
		if (ctrl.w.d_we) begin
			case (ctrl.axis)
				AXIS_X:  dx_q <= acc_q[GAIN_W+D_W-1:GAIN_W];
				AXIS_Y:  dy_q <= acc_q[GAIN_W+D_W-1:GAIN_W];
				default: dh_q <= acc_q[GAIN_W+HEAD_W-1:GAIN_W];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			heading_q <= '0;
		end else begin
			if (ctrl.w.x_we) begin
				x_q <= sat_add(x_q, delta);
			end
			if (ctrl.w.y_we) begin
				y_q <= sat_add(y_q, delta);
			end
			if (ctrl.w.h_we) begin
				heading_q <= heading_q + dh_q;
			end
		end
	end

	assign stat.dt_zero = (dt_q == '0);
	assign pose_cur.pos_x = x_q;
	assign pose_cur.pos_y = y_q;
	assign pose_cur.heading = signed'(heading_q);

endmodule

// ===== src/mecanum_odometry_pose_update.sv =====
`timescale 1ns / 1ps
// mecanum odometry pose integrator: gain registers, sequencer, datapath, output register
// depends on mop_pkg, mop_if, mop_sequencer, mop_datapath and assert_macros.svh
//
// usage:
//   sample: one transaction per odometry step with four signed wheel speeds (1/8 rpm)
//     and step_time in microseconds. cfg: write index 0 for speed_gain, 1 for
//     turn_gain; other indexes are dropped. cfg is always ready; the user must write
//     it only while the block is idle, which the block does not enforce. pose: one
//     transaction per sample: pos_x, pos_y (2^-16 m, saturating), heading (binary angle, wraps).
//   timing: the result is loaded into the output register by the last program step,
//     to which the program skips from the sine lookup when step_time is zero. a new
//     sample is taken only once the sequencer is idle again, not while the last one is
//     in the datapath. the 15-word control program uses one shared 35x18 multiplier:
//     six steps per wheel sum for three sums, then four products for the rotation.
//   stalls: the pose register holds its result until taken; meanwhile the next
//     sample is accepted and computed, and the program waits on its last step
//     while the register is still full.
//   reset: position, heading and both gains clear to zero; the sine rom is constant.
`include "assert_macros.svh"
module mecanum_odometry_pose_update (
	input  logic        clk,
	input  logic        arst_n,
	mop_in_if.sink      sample,
	mop_out_if.source   pose,
	mop_cfg_if.sink     cfg
);
	import mop_pkg::*;

	logic [GAIN_W-1:0] speed_gain_q;
	logic [GAIN_W-1:0] turn_gain_q;
	logic              pose_valid_q;
	pose_t             pose_q;
	pose_t             pose_cur;
	dp_ctrl_t          ctrl;
	dp_stat_t          stat;
	logic              seq_idle;
	logic              start;
	logic              out_free;
	logic              pose_load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_gain_q <= '0;
			turn_gain_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_SPEED_GAIN: speed_gain_q <= cfg.wdata;
				CFG_TURN_GAIN:  turn_gain_q <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	assign sample.ready = seq_idle;
	assign start = sample.valid && seq_idle;
	assign out_free = !pose_valid_q || pose.ready;
	assign pose_load = ctrl.w.done && out_free;

	mop_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.stat     (stat),
		.ctrl     (ctrl),
		.idle     (seq_idle)
	);

	mop_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.sample_in  (sample.payload),
		.speed_gain (speed_gain_q),
		.turn_gain  (turn_gain_q),
		.ctrl       (ctrl),
		.stat       (stat),
		.pose_cur   (pose_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_valid_q <= 1'b0;
		end else if (pose_load) begin
			pose_valid_q <= 1'b1;
		end else if (pose.ready) begin
			pose_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pose_load) begin
			pose_q <= pose_cur;
		end
	end

	assign pose.valid = pose_valid_q;
	assign pose.payload = pose_q;

	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, sample.valid && sample.ready, !sample.ready)
	`ASSERT_IMPL(a_pose_from_done, clk, arst_n, $rose(pose.valid), $past(ctrl.w.done))
	`ASSERT_NEXT(a_wait_full, clk, arst_n, ctrl.w.done && pose.valid && !pose.ready, ctrl.w.done)

endmodule
